FILE: src/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
package spq_pkg;

  localparam int ITEM_WIDTH     = 32;
  localparam int PRIORITY_WIDTH = 16;
  localparam int COUNT_WIDTH    = 5;
  localparam int CAPACITY_DEF   = 16;

  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_DEQUEUE = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [1:0]                       opcode;
    logic [ITEM_WIDTH-1:0]            new_item;
    logic signed [PRIORITY_WIDTH-1:0] new_priority;
  } spq_in_t;

  typedef struct packed {
    logic [1:0]                       status;
    logic [ITEM_WIDTH-1:0]            taken_item;
    logic [ITEM_WIDTH-1:0]            head_item;
    logic signed [PRIORITY_WIDTH-1:0] head_priority;
    logic [COUNT_WIDTH-1:0]           entry_count;
    logic                             is_empty;
  } spq_out_t;

  typedef struct packed {
    logic signed [PRIORITY_WIDTH-1:0] prio;
    logic [ITEM_WIDTH-1:0]            item;
  } spq_entry_t;

  typedef struct packed {
    logic       enq;
    logic       deq;
    spq_entry_t entry;
  } spq_ctrl_t;

endpackage

FILE: src/sorted_priority_queue.sv
// Top level of the min-first sorted priority queue built as a chain of cells.
//
//   channel | direction | payload type      | handshake
//   in_     | input     | spq_pkg::spq_in_t  | in_valid / in_stall
//   out_    | output    | spq_pkg::spq_out_t | out_valid / out_stall
//
// Every cell compares and shifts in parallel on each transaction.
// The result is held in an output register and appears the cycle after acceptance.
// A new transaction is accepted in every cycle in which the output register is empty
// or its result is being taken, so a stalled result holds off the input.
// Reset clears the entry count and the output valid flag; entry contents and output data are not reset.
module sorted_priority_queue #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  spq_pkg::spq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output spq_pkg::spq_out_t out_data
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic                not_empty;
  logic [CW-1:0]       cnt_r;
  logic [CW-1:0]       cnt_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  spq_pkg::spq_out_t   out_data_r;
  spq_pkg::spq_out_t   out_data_nxt;
  spq_pkg::spq_ctrl_t  ctrl;
  logic                accept;
  logic                enq_ok;
  logic                deq_ok;
  logic [1:0]          status;

  spq_pkg::spq_entry_t entry     [CAPACITY];
  spq_pkg::spq_entry_t entry_nxt [CAPACITY];
  logic                shift     [CAPACITY];

  assign not_empty = (cnt_r != '0);
  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    enq_ok  = 1'b0;
    deq_ok  = 1'b0;
    status  = spq_pkg::ST_OK;
    cnt_nxt = cnt_r;
    case (in_data.opcode)
      spq_pkg::OP_ENQUEUE: begin
        if (cnt_r == CW'(CAPACITY)) begin
          status = spq_pkg::ST_OVERFLOW;
        end else begin
          enq_ok  = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      spq_pkg::OP_DEQUEUE: begin
        if (!not_empty) begin
          status = spq_pkg::ST_UNDERFLOW;
        end else begin
          deq_ok  = 1'b1;
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      spq_pkg::OP_CLEAR: begin
        cnt_nxt = '0;
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  assign ctrl.enq        = accept && enq_ok;
  assign ctrl.deq        = accept && deq_ok;
  assign ctrl.entry.prio = in_data.new_priority;
  assign ctrl.entry.item = in_data.new_item;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_cell u_cell (
      .clk          (clk),
      .ctrl_i       (ctrl),
      .occupied_i   (CW'(i) < cnt_r),
      .tail_i       (CW'(i) == cnt_r),
      .left_shift_i ((i == 0) ? 1'b0 : shift[(i == 0) ? 0 : i - 1]),
      .left_i       (entry[(i == 0) ? 0 : i - 1]),
      .right_i      (entry[(i == CAPACITY - 1) ? i : i + 1]),
      .shift_o      (shift[i]),
      .entry_o      (entry[i]),
      .entry_nxt_o  (entry_nxt[i])
    );
  end

  always_comb begin
    out_data_nxt.status        = status;
    out_data_nxt.taken_item    = deq_ok ? entry[0].item : '0;
    out_data_nxt.head_item     = (cnt_nxt != '0) ? entry_nxt[0].item : '0;
    out_data_nxt.head_priority = (cnt_nxt != '0) ? entry_nxt[0].prio : '0;
    out_data_nxt.entry_count   = spq_pkg::COUNT_WIDTH'(cnt_nxt);
    out_data_nxt.is_empty      = (cnt_nxt == '0);
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: src/spq_cell.sv
// One slot of the sorted shift chain, holding a single queue entry.
module spq_cell (
  input  logic               clk,
  input  spq_pkg::spq_ctrl_t ctrl_i,
  input  logic               occupied_i,
  input  logic               tail_i,
  input  logic               left_shift_i,
  input  spq_pkg::spq_entry_t left_i,
  input  spq_pkg::spq_entry_t right_i,
  output logic               shift_o,
  output spq_pkg::spq_entry_t entry_o,
  output spq_pkg::spq_entry_t entry_nxt_o
);

  spq_pkg::spq_entry_t entry_r;
  spq_pkg::spq_entry_t entry_nxt;

  assign shift_o = occupied_i && !(entry_r.prio < ctrl_i.entry.prio);

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl_i.enq) begin
      if (left_shift_i) begin
        entry_nxt = left_i;
      end else if (shift_o || tail_i) begin
        entry_nxt = ctrl_i.entry;
      end
    end else if (ctrl_i.deq) begin
      entry_nxt = right_i;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_o     = entry_r;
  assign entry_nxt_o = entry_nxt;

endmodule
